// File: rtl/gated_vitals_sliding_average_core_macros.svh
// Assertion macros used by the checker of the vitals averaging core.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef GATED_VITALS_SLIDING_AVERAGE_CORE_MACROS_SVH
`define GATED_VITALS_SLIDING_AVERAGE_CORE_MACROS_SVH

// Same-cycle implication.
`define GVSA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gvsa assertion failed");

// Next-cycle implication.
`define GVSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gvsa assertion failed");

`endif

// File: rtl/gvsa_pkg.sv
package gvsa_pkg;

    // Field widths of one reading and one result.
    localparam int HR_W = 12;
    localparam int OX_W = 11;
    localparam int SH_W = 4;

    // Stream data widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    // Input field positions, lowest bit first.
    localparam int IN_HR_LSB    = 0;
    localparam int IN_HR_OK_BIT = 12;
    localparam int IN_OX_LSB    = 13;
    localparam int IN_OX_OK_BIT = 24;
    localparam int IN_BEAT_BIT  = 25;
    localparam int IN_CLEAR_BIT = 26;

    // Output field positions, lowest bit first.
    localparam int OUT_FINGER_BIT = 0;
    localparam int OUT_AHR_LSB    = 1;
    localparam int OUT_AOX_LSB    = 13;
    localparam int OUT_SH_LSB     = 24;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic read;
        logic update;
        logic div_start;
        logic div_sel;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic out_busy;
    } t_dp_status;

endpackage

// File: rtl/gvsa_ctrl.sv
module gvsa_ctrl
    import gvsa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_START_HR,
        S_WAIT_HR,
        S_START_OX,
        S_WAIT_OX,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_ready;

    // Commands decoded from the current state.
    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = i_in_valid && r_ready;
        o_cmd.read      = (r_state == S_READ);
        o_cmd.update    = (r_state == S_UPDATE);
        o_cmd.div_start = (r_state == S_START_HR) || (r_state == S_START_OX);
        o_cmd.div_sel   = (r_state == S_START_OX);
        o_cmd.load_out  = (r_state == S_EMIT) && !i_status.out_busy;
    end

    assign o_in_ready = r_ready;

    // Sequencer: one reading at a time, window update and then two divisions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_ready) begin
                        r_state <= S_READ;
                        r_ready <= 1'b0;
                    end
                end
                S_READ: begin
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_state <= S_START_HR;
                end
                S_START_HR: begin
                    r_state <= S_WAIT_HR;
                end
                S_WAIT_HR: begin
                    if (i_status.div_done) begin
                        r_state <= S_START_OX;
                    end
                end
                S_START_OX: begin
                    r_state <= S_WAIT_OX;
                end
                S_WAIT_OX: begin
                    if (i_status.div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!i_status.out_busy) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

// File: rtl/gvsa_datapath.sv
module gvsa_datapath
    import gvsa_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [OUT_TDATA_W-1:0] o_out_data
);

    localparam int SLOT_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int GROW_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 0;
    localparam int RS_W     = HR_W + GROW_W;
    localparam int OS_W     = OX_W + GROW_W;
    localparam int STEP_W   = $clog2(RS_W + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(WINDOW_DEPTH);

    // Input fields.
    logic [HR_W-1:0] w_in_hr;
    logic            w_in_hr_ok;
    logic [OX_W-1:0] w_in_ox;
    logic            w_in_ox_ok;
    logic            w_in_beat;
    logic            w_in_clear;
    logic            w_in_finger;

    // Captured reading.
    logic [HR_W-1:0] r_hr;
    logic            r_hr_ok;
    logic [OX_W-1:0] r_ox;
    logic            r_ox_ok;
    logic            r_finger;

    // Window storage and bookkeeping.
    logic [HR_W-1:0]         r_mem_hr [WINDOW_DEPTH];
    logic [OX_W-1:0]         r_mem_ox [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] r_valid;
    logic [SLOT_W-1:0]       r_slot;
    logic [CNT_W-1:0]        r_count;
    logic [RS_W-1:0]         r_rsum;
    logic [OS_W-1:0]         r_osum;
    logic [HR_W-1:0]         r_old_hr;
    logic [OX_W-1:0]         r_old_ox;
    logic                    r_old_vld;

    logic [HR_W-1:0] w_new_hr;
    logic [OX_W-1:0] w_new_ox;
    logic [HR_W-1:0] w_old_hr;
    logic [OX_W-1:0] w_old_ox;

    // Shared bit-serial divider.
    logic [STEP_W-1:0] r_div_cnt;
    logic [RS_W-1:0]   r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic              r_div_sel;
    logic [CNT_W:0]    w_trial;
    logic              w_qbit;
    logic [CNT_W-1:0]  w_rem_next;
    logic [RS_W-1:0]   w_quo_next;
    logic [RS_W-1:0]   w_quo_final;

    logic [HR_W-1:0] r_avg_hr;
    logic [OX_W-1:0] r_avg_ox;

    // Output register.
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TDATA_W-1:0] w_out_pack;
    logic [CNT_W+SH_W-1:0]  w_count_ext;

    // Unpack the reading and detect a finger.
    assign w_in_hr     = i_in_data[IN_HR_LSB +: HR_W];
    assign w_in_hr_ok  = i_in_data[IN_HR_OK_BIT];
    assign w_in_ox     = i_in_data[IN_OX_LSB +: OX_W];
    assign w_in_ox_ok  = i_in_data[IN_OX_OK_BIT];
    assign w_in_beat   = i_in_data[IN_BEAT_BIT];
    assign w_in_clear  = i_in_data[IN_CLEAR_BIT];
    assign w_in_finger = (w_in_hr_ok && (w_in_hr != '0) && w_in_ox_ok && (w_in_ox != '0))
                         || w_in_beat;

    // Capture the reading on its transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hr     <= w_in_hr;
            r_hr_ok  <= w_in_hr_ok;
            r_ox     <= w_in_ox;
            r_ox_ok  <= w_in_ox_ok;
            r_finger <= w_in_finger;
        end
    end

    // Invalid values enter the window as zero; unwritten entries read as zero.
    assign w_new_hr = r_hr_ok ? r_hr : '0;
    assign w_new_ox = r_ox_ok ? r_ox : '0;
    assign w_old_hr = r_old_vld ? r_old_hr : '0;
    assign w_old_ox = r_old_vld ? r_old_ox : '0;

    // Window memories: read the slot about to be replaced, then write it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_old_hr  <= r_mem_hr[r_slot];
            r_old_ox  <= r_mem_ox[r_slot];
            r_old_vld <= r_valid[r_slot];
        end
        if (i_cmd.update && r_finger) begin
            r_mem_hr[r_slot] <= w_new_hr;
            r_mem_ox[r_slot] <= w_new_ox;
        end
    end

    // Valid bits, write slot, fill count and running sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_slot  <= '0;
            r_count <= '0;
            r_rsum  <= '0;
            r_osum  <= '0;
        end else if (i_cmd.capture && w_in_clear) begin
            r_valid <= '0;
            r_slot  <= '0;
            r_count <= '0;
            r_rsum  <= '0;
            r_osum  <= '0;
        end else if (i_cmd.update && r_finger) begin
            r_valid[r_slot] <= 1'b1;
            r_rsum <= r_rsum - RS_W'(w_old_hr) + RS_W'(w_new_hr);
            r_osum <= r_osum - OS_W'(w_old_ox) + OS_W'(w_new_ox);
            r_slot <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
            if (r_count != DEPTH_CNT) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // One restoring division step: the top sum bit shifts into the remainder, the quotient bit shifts in below.
    assign w_trial     = {r_rem, r_quo[RS_W-1]};
    assign w_qbit      = (w_trial >= {1'b0, r_count});
    assign w_rem_next  = w_qbit ? CNT_W'(w_trial - {1'b0, r_count}) : w_trial[CNT_W-1:0];
    assign w_quo_next  = {r_quo[RS_W-2:0], w_qbit};
    assign w_quo_final = (r_count == '0) ? '0 : w_quo_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_cnt <= STEP_W'(RS_W);
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo     <= i_cmd.div_sel ? RS_W'(r_osum) : r_rsum;
            r_rem     <= '0;
            r_div_sel <= i_cmd.div_sel;
        end else if (r_div_cnt != '0) begin
            r_quo <= w_quo_next;
            r_rem <= w_rem_next;
        end
    end

    // Store the quotient on the last step; an empty window averages to zero.
    always_ff @(posedge i_clk) begin
        if (r_div_cnt == STEP_W'(1)) begin
            if (r_div_sel) begin
                r_avg_ox <= w_quo_final[OX_W-1:0];
            end else begin
                r_avg_hr <= w_quo_final[HR_W-1:0];
            end
        end
    end

    // Pack the result.
    assign w_count_ext = {{SH_W{1'b0}}, r_count};
    always_comb begin
        w_out_pack                           = '0;
        w_out_pack[OUT_FINGER_BIT]           = r_finger;
        w_out_pack[OUT_AHR_LSB +: HR_W]      = r_avg_hr;
        w_out_pack[OUT_AOX_LSB +: OX_W]      = r_avg_ox;
        w_out_pack[OUT_SH_LSB +: SH_W]       = w_count_ext[SH_W-1:0];
    end

    // Output register holds a result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= w_out_pack;
        end
    end

    assign o_status.div_done = (r_div_cnt == '0);
    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

// File: rtl/gated_vitals_sliding_average_core.sv
// Sliding-window average of pulse-oximeter readings. Each reading on the slave
// stream gives exactly one result on the master stream. A finger counts as
// present when both readings are valid and nonzero or a beat was seen; only
// then do the two values (zero where invalid) enter ring windows of
// WINDOW_DEPTH entries. A set clear bit empties both windows before the
// reading is handled. Results carry the finger flag, both window means
// (truncated, zero when empty) and the number of entries held (low four bits).
// Both means are formed in turn by one shared bit-serial divider; readings are
// handled one at a time, and a finished result waits in an output register
// while the next reading is taken in.
module gated_vitals_sliding_average_core
    import gvsa_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // heart_rate[11:0], heart_rate_valid[12], oxygen_saturation[23:13],
    // oxygen_valid[24], beat_seen[25], clear_window[26], zeros above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // finger_present[0], average_heart_rate[12:1], average_oxygen[23:13],
    // samples_held[27:24], zeros above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer.
    gvsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Windows, sums, divider and output register.
    gvsa_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// File: rtl/gvsa_checker.sv
`include "gated_vitals_sliding_average_core_macros.svh"

module gvsa_checker
    import gvsa_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic w_in_xfer;
    logic w_small;
    logic [SH_W-1:0] w_held;

    assign w_in_xfer = s_axis_tvalid && s_axis_tready;
    assign w_small   = (WINDOW_DEPTH < 16);
    assign w_held    = m_axis_tdata[OUT_SH_LSB +: SH_W];

    // A stalled result holds.
    `GVSA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

    // Readings are handled one at a time.
    `GVSA_ASSERT_NEXT(a_one_at_a_time, w_in_xfer, !s_axis_tready)

    // The window never reports more entries than its depth.
    `GVSA_ASSERT_IMPL(a_held_bound, m_axis_tvalid && w_small, w_held <= SH_W'(WINDOW_DEPTH))

    // An empty window reports zero means.
    `GVSA_ASSERT_IMPL(a_empty_zero, m_axis_tvalid && w_small && (w_held == '0),
        (m_axis_tdata[OUT_AHR_LSB +: HR_W] == '0) && (m_axis_tdata[OUT_AOX_LSB +: OX_W] == '0))

    // Padding above the result fields stays zero.
    `GVSA_ASSERT_IMPL(a_pad_zero, m_axis_tvalid,
        m_axis_tdata[OUT_TDATA_W-1:OUT_SH_LSB+SH_W] == '0)

endmodule

bind gated_vitals_sliding_average_core gvsa_checker #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
) u_gvsa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import gvsa_pkg::*;

    localparam int WINDOW_DEPTH = 8;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_READINGS = 1450;
    localparam int MAX_REPORTS  = 10;

    // One result as the block reports it.
    typedef struct {
        logic            finger;
        logic [HR_W-1:0] avg_hr;
        logic [OX_W-1:0] avg_ox;
        logic [SH_W-1:0] held;
    } t_vitals;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // heart_rate[11:0], heart_rate_valid[12], oxygen_saturation[23:13],
    // oxygen_valid[24], beat_seen[25], clear_window[26], zeros above
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // finger_present[0], average_heart_rate[12:1], average_oxygen[23:13],
    // samples_held[27:24], zeros above
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    gated_vitals_sliding_average_core #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Readings waiting to be sent and results waiting to be seen.
    logic [IN_TDATA_W-1:0] pending_readings[$];
    t_vitals               expected_vitals[$];
    int                    total_readings = 0;
    int                    readings_taken = 0;
    int                    error_count = 0;
    int                    cycle_count = 0;
    logic                  reading_taken = 1'b0;

    // Shadow copy of the window state.
    int unsigned rate_hist[WINDOW_DEPTH];
    int unsigned oxygen_hist[WINDOW_DEPTH];
    int unsigned next_slot = 0;
    int unsigned entries_held = 0;
    int unsigned rate_total = 0;
    int unsigned oxygen_total = 0;

    // Sender burst and receiver stall pattern state.
    int burst_left = 0;
    int gap_left = 0;
    int accept_run = 0;
    int stall_left = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Updates the shadow windows with one reading and returns the expected result.
    function automatic t_vitals predict_vitals(input logic [IN_TDATA_W-1:0] word);
        logic [HR_W-1:0] hr;
        logic [OX_W-1:0] ox;
        logic            hr_ok;
        logic            ox_ok;
        logic            beat;
        logic            clr;
        int unsigned     new_hr;
        int unsigned     new_ox;
        t_vitals         res;
        hr    = word[IN_HR_LSB +: HR_W];
        ox    = word[IN_OX_LSB +: OX_W];
        hr_ok = word[IN_HR_OK_BIT];
        ox_ok = word[IN_OX_OK_BIT];
        beat  = word[IN_BEAT_BIT];
        clr   = word[IN_CLEAR_BIT];

        // A clear request empties everything before the reading is handled.
        if (clr) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                rate_hist[i] = 0;
                oxygen_hist[i] = 0;
            end
            next_slot = 0;
            entries_held = 0;
            rate_total = 0;
            oxygen_total = 0;
        end

        res.finger = (hr_ok && hr != 0 && ox_ok && ox != 0) || beat;

        // Invalid values enter the window as zero.
        if (res.finger) begin
            new_hr = hr_ok ? hr : 0;
            new_ox = ox_ok ? ox : 0;
            rate_total = rate_total - rate_hist[next_slot] + new_hr;
            oxygen_total = oxygen_total - oxygen_hist[next_slot] + new_ox;
            rate_hist[next_slot] = new_hr;
            oxygen_hist[next_slot] = new_ox;
            next_slot = (next_slot == WINDOW_DEPTH - 1) ? 0 : next_slot + 1;
            if (entries_held < WINDOW_DEPTH) begin
                entries_held++;
            end
        end

        res.avg_hr = '0;
        res.avg_ox = '0;
        if (entries_held > 0) begin
            res.avg_hr = HR_W'(rate_total / entries_held);
            res.avg_ox = OX_W'(oxygen_total / entries_held);
        end
        res.held = SH_W'(entries_held);
        return res;
    endfunction

    // Packs one reading and appends it to the send queue.
    task automatic queue_reading(input logic [HR_W-1:0] hr, input logic hr_ok,
                                 input logic [OX_W-1:0] ox, input logic ox_ok,
                                 input logic beat, input logic clr);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[IN_HR_LSB +: HR_W] = hr;
        word[IN_HR_OK_BIT]      = hr_ok;
        word[IN_OX_LSB +: OX_W] = ox;
        word[IN_OX_OK_BIT]      = ox_ok;
        word[IN_BEAT_BIT]       = beat;
        word[IN_CLEAR_BIT]      = clr;
        pending_readings.push_back(word);
        total_readings++;
    endtask

    // Sender: presents readings in bursts separated by random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !reading_taken) begin
                // Hold the current reading until its transfer completes.
            end else if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_readings.size() > 0) begin
                s_axis_tdata <= pending_readings.pop_front();
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: accepts in runs and stalls in between, with long open stretches.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (accept_run > 0) begin
                accept_run--;
                m_axis_tready <= 1'b1;
            end else begin
                accept_run = ($urandom_range(0, 9) == 0) ? 400 : $urandom_range(1, 40);
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Input transfers feed the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            reading_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_vitals.push_back(predict_vitals(s_axis_tdata));
                readings_taken++;
            end
        end
    end

    // Output transfers are checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_vitals got;
        t_vitals want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.finger = m_axis_tdata[OUT_FINGER_BIT];
            got.avg_hr = m_axis_tdata[OUT_AHR_LSB +: HR_W];
            got.avg_ox = m_axis_tdata[OUT_AOX_LSB +: OX_W];
            got.held   = m_axis_tdata[OUT_SH_LSB +: SH_W];
            if (expected_vitals.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("Unexpected result: finger %0d hr %0d ox %0d held %0d",
                             got.finger, got.avg_hr, got.avg_ox, got.held);
                end
            end else begin
                want = expected_vitals.pop_front();
                if (got.finger !== want.finger || got.avg_hr !== want.avg_hr ||
                    got.avg_ox !== want.avg_ox || got.held !== want.held) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display({"Mismatch: expected finger %0d hr %0d ox %0d held %0d,",
                                  " got finger %0d hr %0d ox %0d held %0d"},
                                 want.finger, want.avg_hr, want.avg_ox, want.held,
                                 got.finger, got.avg_hr, got.avg_ox, got.held);
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int               kind;
        logic [HR_W-1:0]  hr;
        logic [OX_W-1:0]  ox;
        logic             hr_ok;
        logic             ox_ok;
        logic             beat;
        logic             clr;

        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            rate_hist[i] = 0;
            oxygen_hist[i] = 0;
        end

        // Directed readings: empty window, gating, extremes and clears.
        queue_reading(12'd0, 1'b0, 11'd0, 1'b0, 1'b0, 1'b0);
        queue_reading(12'd0, 1'b1, 11'd1600, 1'b1, 1'b0, 1'b0);
        queue_reading(12'd1200, 1'b1, 11'd0, 1'b1, 1'b0, 1'b0);
        queue_reading(12'd4095, 1'b1, 11'd2047, 1'b1, 1'b0, 1'b0);
        queue_reading(12'd0, 1'b1, 11'd0, 1'b1, 1'b1, 1'b0);
        queue_reading(12'd3000, 1'b0, 11'd1500, 1'b0, 1'b1, 1'b0);
        queue_reading(12'd4095, 1'b1, 11'd1600, 1'b0, 1'b1, 1'b0);
        queue_reading(12'd1, 1'b1, 11'd1, 1'b1, 1'b0, 1'b0);
        // Fill the window at the largest values so that it wraps at full sums.
        for (int i = 0; i < WINDOW_DEPTH + 1; i++) begin
            queue_reading(12'd4095, 1'b1, 11'd2047, 1'b1, 1'b1, 1'b0);
        end
        queue_reading(12'd4095, 1'b0, 11'd2047, 1'b1, 1'b0, 1'b0);
        queue_reading(12'd800, 1'b1, 11'd0, 1'b0, 1'b0, 1'b1);
        queue_reading(12'd1200, 1'b1, 11'd1568, 1'b1, 1'b0, 1'b1);
        queue_reading(12'd1100, 1'b1, 11'd1552, 1'b1, 1'b1, 1'b1);
        queue_reading(12'hAAA, 1'b1, 11'h555, 1'b1, 1'b1, 1'b0);
        queue_reading(12'h555, 1'b1, 11'h2AA, 1'b1, 1'b0, 1'b0);

        // Random readings: mostly well-formed finger readings, some gated or cleared.
        for (int n = 0; n < RANDOM_READINGS; n++) begin
            kind = int'($urandom_range(0, 99));
            clr = (kind < 3);
            beat = 1'($urandom_range(0, 1));
            if (kind < 75) begin
                hr_ok = 1'b1;
                ox_ok = 1'b1;
                hr = ($urandom_range(0, 4) == 0) ? HR_W'($urandom_range(1, 4095))
                                                 : HR_W'($urandom_range(640, 3200));
                ox = ($urandom_range(0, 5) == 0) ? OX_W'($urandom_range(1, 2047))
                                                 : OX_W'($urandom_range(1100, 1600));
            end else if (kind < 88) begin
                hr_ok = 1'($urandom_range(0, 1));
                ox_ok = 1'($urandom_range(0, 1));
                hr = HR_W'($urandom_range(0, 4095));
                ox = OX_W'($urandom_range(0, 2047));
            end else begin
                hr_ok = 1'($urandom_range(0, 1));
                ox_ok = 1'($urandom_range(0, 1));
                hr = ($urandom_range(0, 1) == 0) ? '0 : HR_W'($urandom_range(0, 4095));
                ox = (hr != 0) ? '0 : OX_W'($urandom_range(0, 2047));
            end
            queue_reading(hr, hr_ok, ox, ox_ok, beat, clr);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every reading to be taken and every result to be seen.
        while (readings_taken < total_readings) @(negedge i_clk);
        while (expected_vitals.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
